// File: rtl/core/attitude_from_accel_mag_core_macros.svh
// ----------------------------------------------------------------------------
// Attitude core assertion macros
// Shared concurrent assertion forms for the attitude core.
// ----------------------------------------------------------------------------
`ifndef ATTITUDE_FROM_ACCEL_MAG_CORE_MACROS_SVH
`define ATTITUDE_FROM_ACCEL_MAG_CORE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define AFAM_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define AFAM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/afam_pkg.sv
// ----------------------------------------------------------------------------
// Attitude core package
// Widths, angle constants, lane codes and the arctangent table.
// ----------------------------------------------------------------------------
package afam_pkg;

   // Scaled operand width: sample bits plus fraction bits
   localparam int ROOT_W             = 30;
   localparam int XY_W               = ROOT_W + 2;
   localparam int Z_W                = 25;
   localparam int ANG_W              = 16;
   localparam int PITCH_W            = 15;
   localparam int DIFF_W             = 18;
   localparam int RSP_W              = 48;
   localparam int CSR_W              = 16;
   localparam int LANES              = 3;
   localparam int ATAN_LEN           = 24;
   localparam int CORDIC_STAGES_DEF  = 16;
   localparam int SAMPLE_BITS_DEF    = 16;

   // Lane codes
   localparam int LANE_PITCH = 0;
   localparam int LANE_ROLL  = 1;
   localparam int LANE_HEAD  = 2;

   typedef logic signed [XY_W-1:0]   xy_type;
   typedef logic signed [Z_W-1:0]    z_type;
   typedef logic signed [ANG_W-1:0]  angle_type;
   typedef logic signed [DIFF_W-1:0] diff_type;

   typedef struct packed {
      logic y_zero;
      logic x_neg;
   } lane_flags_type;

   // Accumulator units are 1/25600 degree
   localparam z_type HALF_TURN = 25'sd4608000;
   localparam z_type ROUND_BIAS = 25'sd128;

   localparam angle_type ANG_HALF    = 16'sd18000;
   localparam angle_type ANG_QUARTER = 16'sd9000;
   localparam diff_type  DIFF_HALF   = 18'sd18000;
   localparam diff_type  DIFF_FULL   = 18'sd36000;
   localparam angle_type DECL_RESET  = 16'sd349;

   // atan(2^-i) in accumulator units, rounded to nearest
   function automatic z_type atan_entry(input int i);
      z_type r;
      case (i)
         0:       r = 25'sd1152000;
         1:       r = 25'sd680065;
         2:       r = 25'sd359328;
         3:       r = 25'sd182400;
         4:       r = 25'sd91554;
         5:       r = 25'sd45822;
         6:       r = 25'sd22916;
         7:       r = 25'sd11459;
         8:       r = 25'sd5730;
         9:       r = 25'sd2865;
         10:      r = 25'sd1432;
         11:      r = 25'sd716;
         12:      r = 25'sd358;
         13:      r = 25'sd179;
         14:      r = 25'sd90;
         15:      r = 25'sd45;
         16:      r = 25'sd22;
         17:      r = 25'sd11;
         18:      r = 25'sd6;
         19:      r = 25'sd3;
         20:      r = 25'sd1;
         21:      r = 25'sd1;
         default: r = 25'sd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/attitude_from_accel_mag_core.sv
// ----------------------------------------------------------------------------
// Attitude core top level
// Pitch, roll and heading in hundredths of a degree from one sensor sample.
// ----------------------------------------------------------------------------
// Pipeline: square, 30 root stages, fold, CORDIC_STAGES rotations, round,
//          correction, output register.
// Throughput: one transaction per cycle; the whole pipe holds while the
//             output register is full and not taken.
// Reset: synchronous, clears all valid bits and loads declination 3.49 deg.
`include "attitude_from_accel_mag_core_macros.svh"

module attitude_from_accel_mag_core #(
   parameter int CORDIC_STAGES = afam_pkg::CORDIC_STAGES_DEF,
   parameter int SAMPLE_BITS   = afam_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z, zero fill
   input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // pitch_angle, roll_angle, heading_angle, zero fill
   output logic [afam_pkg::RSP_W-1:0]             rsp_tdata,
   input  logic                                   csr_wen,
   input  logic [afam_pkg::CSR_W-1:0]             csr_wdata
);
   import afam_pkg::*;

   localparam int S      = SAMPLE_BITS;
   localparam int FRAC_W = ROOT_W - SAMPLE_BITS;
   localparam int PAY_W  = 5 * SAMPLE_BITS;

   typedef logic signed [S-1:0] sample_type;

   function automatic xy_type scale_sample(input sample_type v);
      xy_type r;
      r = XY_W'(v);
      return r <<< FRAC_W;
   endfunction

   logic en;

   sample_type ax, ay, az, mx, my;
   logic [2*S-1:0] sq_ay_in, sq_az_in;

   logic           sq_valid_ff;
   logic [2*S-1:0] sq_ay_ff, sq_az_ff;
   logic [PAY_W-1:0] samp_ff;

   logic             root_valid;
   logic [ROOT_W-1:0] root;
   logic [PAY_W-1:0] root_pay;
   sample_type       r_ax, r_ay, r_az, r_mx, r_my;

   xy_type           cor_y [LANES];
   xy_type           cor_x [LANES];
   logic [1:0]       cor_pay_in;
   logic             cor_valid;
   angle_type        cor_angle [LANES];
   logic [1:0]       cor_pay;

   angle_type        decl_ff;

   logic             post_valid_ff;
   angle_type        pitch_post_ff, pitch_post_in;
   angle_type        roll_post_ff;
   diff_type         head_diff_ff, head_diff_in;
   angle_type        head_sel;

   logic             rsp_valid_ff;
   logic signed [PITCH_W-1:0] pitch_ff;
   angle_type        roll_ff;
   angle_type        head_ff, head_in;

   // Advance the whole pipe unless the output register is held
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Unpack the transaction; mag_z is not used
   assign ax = req_tdata[0*S +: S];
   assign ay = req_tdata[1*S +: S];
   assign az = req_tdata[2*S +: S];
   assign mx = req_tdata[3*S +: S];
   assign my = req_tdata[4*S +: S];

   assign sq_ay_in = ay * ay;
   assign sq_az_in = az * az;

   // Square the accelerometer y and z axes
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff <= req_tvalid;
      end
      if (en) begin
         sq_ay_ff <= sq_ay_in;
         sq_az_ff <= sq_az_in;
         samp_ff  <= {my, mx, az, ay, ax};
      end
   end

   afam_sqrt #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PAYLOAD_W   (PAY_W)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (sq_valid_ff),
      .in_radicand (sq_ay_ff + sq_az_ff),
      .in_payload  (samp_ff),
      .out_valid   (root_valid),
      .out_root    (root),
      .out_payload (root_pay)
   );

   assign r_ax = root_pay[0*S +: S];
   assign r_ay = root_pay[1*S +: S];
   assign r_az = root_pay[2*S +: S];
   assign r_mx = root_pay[3*S +: S];
   assign r_my = root_pay[4*S +: S];

   // Build the three atan2 operand pairs
   always_comb begin
      cor_y[LANE_PITCH] = -scale_sample(r_ax);
      cor_x[LANE_PITCH] = XY_W'(root);
      cor_y[LANE_ROLL]  = scale_sample(r_ay);
      cor_x[LANE_ROLL]  = scale_sample(r_az);
      cor_y[LANE_HEAD]  = scale_sample(r_mx);
      cor_x[LANE_HEAD]  = scale_sample(r_my);
      cor_pay_in        = {(r_my == '0), r_mx[S-1]};
   end

   afam_cordic #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .PAYLOAD_W     (2)
   ) u_cordic (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (root_valid),
      .in_y        (cor_y),
      .in_x        (cor_x),
      .in_payload  (cor_pay_in),
      .out_valid   (cor_valid),
      .out_angle   (cor_angle),
      .out_payload (cor_pay)
   );

   // Hold the declination register
   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= DECL_RESET;
      end else if (csr_wen) begin
         decl_ff <= csr_wdata;
      end
   end

   // Limit pitch, pick heading source and subtract declination
   always_comb begin
      if (cor_angle[LANE_PITCH] > ANG_QUARTER) begin
         pitch_post_in = ANG_QUARTER;
      end else if (cor_angle[LANE_PITCH] < -ANG_QUARTER) begin
         pitch_post_in = -ANG_QUARTER;
      end else begin
         pitch_post_in = cor_angle[LANE_PITCH];
      end
      if (cor_pay[1]) begin
         head_sel = cor_pay[0] ? ANG_HALF : '0;
      end else begin
         head_sel = cor_angle[LANE_HEAD];
      end
      head_diff_in = DIFF_W'(head_sel) - DIFF_W'(decl_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_valid_ff <= 1'b0;
      end else if (en) begin
         post_valid_ff <= cor_valid;
      end
      if (en) begin
         pitch_post_ff <= pitch_post_in;
         roll_post_ff  <= cor_angle[LANE_ROLL];
         head_diff_ff  <= head_diff_in;
      end
   end

   // Wrap heading once into the half-turn range
   always_comb begin
      if (head_diff_ff > DIFF_HALF) begin
         head_in = ANG_W'(head_diff_ff - DIFF_FULL);
      end else if (head_diff_ff < -DIFF_HALF) begin
         head_in = ANG_W'(head_diff_ff + DIFF_FULL);
      end else begin
         head_in = ANG_W'(head_diff_ff);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= post_valid_ff;
      end
      if (en) begin
         pitch_ff <= PITCH_W'(pitch_post_ff);
         roll_ff  <= roll_post_ff;
         head_ff  <= head_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, head_ff, roll_ff, pitch_ff};

   // Range checks on delivered angles and a hold check on a stalled heading
   `AFAM_ASSERT_SAME(a_pitch_range, clock, reset, rsp_valid_ff,
      (pitch_ff <= 15'sd9000) && (pitch_ff >= -15'sd9000), "pitch out of range")
   `AFAM_ASSERT_SAME(a_roll_range, clock, reset, rsp_valid_ff,
      (roll_ff <= ANG_HALF) && (roll_ff >= -ANG_HALF), "roll out of range")
   `AFAM_ASSERT_SAME(a_head_range, clock, reset, rsp_valid_ff,
      (head_ff <= ANG_HALF) && (head_ff >= -ANG_HALF), "heading out of range")
   `AFAM_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid_ff && !rsp_tready,
      rsp_valid_ff && $stable(head_ff), "held result changed")

endmodule

// File: rtl/core/afam_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per register stage; side data travels alongside.
// ----------------------------------------------------------------------------
module afam_sqrt #(
   parameter int SAMPLE_BITS = afam_pkg::SAMPLE_BITS_DEF,
   parameter int PAYLOAD_W   = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [2*SAMPLE_BITS-1:0]    in_radicand,
   input  logic [PAYLOAD_W-1:0]        in_payload,
   output logic                        out_valid,
   output logic [afam_pkg::ROOT_W-1:0] out_root,
   output logic [PAYLOAD_W-1:0]        out_payload
);
   import afam_pkg::*;

   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int REM_W = ROOT_W + 3;

   logic                 valid_ff [ROOT_W];
   logic [ROOT_W-1:0]    root_ff  [ROOT_W];
   logic [REM_W-1:0]     rem_ff   [ROOT_W];
   logic [SQ_W-1:0]      sq_ff    [ROOT_W];
   logic [PAYLOAD_W-1:0] pay_ff   [ROOT_W];

   genvar k;
   for (k = 0; k < ROOT_W; k++) begin : g_step
      logic                 valid_src;
      logic [ROOT_W-1:0]    root_src;
      logic [REM_W-1:0]     rem_src;
      logic [SQ_W-1:0]      sq_src;
      logic [PAYLOAD_W-1:0] pay_src;
      logic [1:0]           pair;
      logic [REM_W-1:0]     cur;
      logic [REM_W-1:0]     trial;
      logic [REM_W-1:0]     rem_in;
      logic [ROOT_W-1:0]    root_in;

      // Select the previous stage or the input
      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign root_src  = '0;
         assign rem_src   = '0;
         assign sq_src    = in_radicand;
         assign pay_src   = in_payload;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign sq_src    = sq_ff[k-1];
         assign pay_src   = pay_ff[k-1];
      end

      // Radicand is the square sum shifted up; low pairs are zero
      if (SQ_W - 2 - 2 * k >= 0) begin : g_pair
         assign pair = sq_src[SQ_W-1-2*k -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      // Try the next root bit
      always_comb begin
         cur   = {rem_src[REM_W-3:0], pair};
         trial = {1'b0, root_src, 2'b01};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_src[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_src[ROOT_W-2:0], 1'b0};
         end
      end

      // Advance the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
         if (en) begin
            root_ff[k] <= root_in;
            rem_ff[k]  <= rem_in;
            sq_ff[k]   <= sq_src;
            pay_ff[k]  <= pay_src;
         end
      end
   end

   assign out_valid   = valid_ff[ROOT_W-1];
   assign out_root    = root_ff[ROOT_W-1];
   assign out_payload = pay_ff[ROOT_W-1];

endmodule

// File: rtl/core/afam_cordic.sv
// ----------------------------------------------------------------------------
// Three-lane vectoring CORDIC pipeline
// Half-plane fold, one micro-rotation per stage, then round, clamp and zero-ordinate case.
// ----------------------------------------------------------------------------
module afam_cordic #(
   parameter int CORDIC_STAGES = afam_pkg::CORDIC_STAGES_DEF,
   parameter int PAYLOAD_W     = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  afam_pkg::xy_type     in_y [afam_pkg::LANES],
   input  afam_pkg::xy_type     in_x [afam_pkg::LANES],
   input  logic [PAYLOAD_W-1:0] in_payload,
   output logic                 out_valid,
   output afam_pkg::angle_type  out_angle [afam_pkg::LANES],
   output logic [PAYLOAD_W-1:0] out_payload
);
   import afam_pkg::*;

   localparam int N = CORDIC_STAGES;

   logic                 valid_ff [N+1];
   xy_type               x_ff     [N+1][LANES];
   xy_type               y_ff     [N+1][LANES];
   z_type                z_ff     [N+1][LANES];
   lane_flags_type       flag_ff  [N+1][LANES];
   logic [PAYLOAD_W-1:0] pay_ff   [N+1];

   xy_type               x_prep_in [LANES];
   xy_type               y_prep_in [LANES];
   z_type                z_prep_in [LANES];
   lane_flags_type       flag_prep_in [LANES];

   logic                 out_valid_ff;
   angle_type            angle_ff [LANES];
   angle_type            angle_in [LANES];
   logic [PAYLOAD_W-1:0] out_pay_ff;

   // Fold the left half-plane onto the right
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         flag_prep_in[l].x_neg  = in_x[l][XY_W-1];
         flag_prep_in[l].y_zero = (in_y[l] == '0);
         if (in_x[l][XY_W-1]) begin
            x_prep_in[l] = -in_x[l];
            y_prep_in[l] = -in_y[l];
            z_prep_in[l] = (in_y[l] > 0) ? HALF_TURN : -HALF_TURN;
         end else begin
            x_prep_in[l] = in_x[l];
            y_prep_in[l] = in_y[l];
            z_prep_in[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]    <= x_prep_in;
         y_ff[0]    <= y_prep_in;
         z_ff[0]    <= z_prep_in;
         flag_ff[0] <= flag_prep_in;
         pay_ff[0]  <= in_payload;
      end
   end

   // Micro-rotation stages
   genvar i;
   for (i = 0; i < N; i++) begin : g_rot
      xy_type x_in [LANES];
      xy_type y_in [LANES];
      z_type  z_in [LANES];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (y_ff[i][l] > 0) begin
               x_in[l] = x_ff[i][l] + (y_ff[i][l] >>> i);
               y_in[l] = y_ff[i][l] - (x_ff[i][l] >>> i);
               z_in[l] = z_ff[i][l] + atan_entry(i);
            end else begin
               x_in[l] = x_ff[i][l] - (y_ff[i][l] >>> i);
               y_in[l] = y_ff[i][l] + (x_ff[i][l] >>> i);
               z_in[l] = z_ff[i][l] - atan_entry(i);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            flag_ff[i+1] <= flag_ff[i];
            pay_ff[i+1]  <= pay_ff[i];
         end
      end
   end

   // Round to hundredths, clamp, and apply the zero-ordinate case
   always_comb begin
      z_type rnd;
      for (int l = 0; l < LANES; l++) begin
         rnd = (z_ff[N][l] + ROUND_BIAS) >>> 8;
         if (flag_ff[N][l].y_zero) begin
            angle_in[l] = flag_ff[N][l].x_neg ? ANG_HALF : '0;
         end else if (rnd > Z_W'(ANG_HALF)) begin
            angle_in[l] = ANG_HALF;
         end else if (rnd < -Z_W'(ANG_HALF)) begin
            angle_in[l] = -ANG_HALF;
         end else begin
            angle_in[l] = ANG_W'(rnd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[N];
      end
      if (en) begin
         angle_ff   <= angle_in;
         out_pay_ff <= pay_ff[N];
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_angle   = angle_ff;
   assign out_payload = out_pay_ff;

endmodule

// File: test/tb_attitude_from_accel_mag_core.sv
// ----------------------------------------------------------------------------
// Attitude core testbench
// Sends accelerometer and magnetometer samples through the streaming port,
// recomputes pitch, roll and heading with a bit-exact CORDIC of its own and
// compares every result field. It runs under several declination settings
// and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_attitude_from_accel_mag_core;
   import afam_pkg::*;

   localparam int  SAMPLE_BITS = 16;
   localparam int  FRAC_BITS   = 30 - SAMPLE_BITS;
   localparam int  DRAIN_WAIT  = 80;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  MAX_REPORTS = 10;

   typedef struct {
      logic [PITCH_W-1:0] pitch;
      logic [ANG_W-1:0]   roll;
      logic [ANG_W-1:0]   heading;
   } attitude_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
   logic [95:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   // pitch_angle, roll_angle, heading_angle, zero fill
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_wen;
   logic [CSR_W-1:0]     csr_wdata;

   attitude_type         pending_angles[$];
   logic [CSR_W-1:0]     decl_setting;
   int                   send_idle_pct;
   int                   stall_pct;
   int                   error_count;
   int                   cycle_count;

   attitude_from_accel_mag_core #(
      .CORDIC_STAGES(16),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Arctangent of 2^-i in 1/25600 degree
   function automatic longint atan_step(input int i);
      longint steps[24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
                            11459, 5730, 2865, 1432, 716, 358, 179, 90, 45,
                            22, 11, 6, 3, 1, 1, 0, 0};
      return steps[i];
   endfunction

   // Vectoring CORDIC, result in hundredths of a degree
   function automatic longint atan2_cdeg(input longint y_in, input longint x_in);
      longint y;
      longint x;
      longint z;
      longint dx;
      longint dy;
      y = y_in;
      x = x_in;
      z = 0;
      if (y == 0) begin
         return (x < 0) ? 18000 : 0;
      end
      // fold the left half plane onto the right
      if (x < 0) begin
         z = (y > 0) ? 4608000 : -4608000;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx;
            y -= dy;
            z += atan_step(i);
         end else begin
            x -= dx;
            y += dy;
            z -= atan_step(i);
         end
      end
      z = (z + 128) >>> 8;
      if (z > 18000) z = 18000;
      if (z < -18000) z = -18000;
      return z;
   endfunction

   // Floor integer square root
   function automatic longint unsigned floor_sqrt(input longint unsigned v_in);
      longint unsigned v;
      longint unsigned r;
      longint unsigned b;
      v = v_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic attitude_type predict_attitude(input logic [95:0] sample);
      longint       ax;
      longint       ay;
      longint       az;
      longint       mx;
      longint       my;
      longint       mag;
      longint       pitch;
      longint       roll;
      longint       head;
      attitude_type a;
      ax = longint'($signed(sample[15:0]));
      ay = longint'($signed(sample[31:16]));
      az = longint'($signed(sample[47:32]));
      mx = longint'($signed(sample[63:48]));
      my = longint'($signed(sample[79:64]));
      mag = longint'(floor_sqrt(longint'(ay * ay + az * az) << (2 * FRAC_BITS)));
      pitch = atan2_cdeg(-ax <<< FRAC_BITS, mag);
      if (pitch > 9000) pitch = 9000;
      if (pitch < -9000) pitch = -9000;
      roll = atan2_cdeg(ay <<< FRAC_BITS, az <<< FRAC_BITS);
      if (my == 0) begin
         head = (mx < 0) ? 18000 : 0;
      end else begin
         head = atan2_cdeg(mx <<< FRAC_BITS, my <<< FRAC_BITS);
      end
      // subtract declination, wrap once
      head -= longint'($signed(decl_setting));
      if (head > 18000) head -= 36000;
      else if (head < -18000) head += 36000;
      a.pitch   = pitch[PITCH_W-1:0];
      a.roll    = roll[ANG_W-1:0];
      a.heading = head[ANG_W-1:0];
      return a;
   endfunction

   // Offer one sample; hold it until the block takes it
   task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] az, input logic [15:0] mx,
                              input logic [15:0] my, input logic [15:0] mz);
      logic [95:0] sample;
      sample = {mz, my, mx, az, ay, ax};
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_angles.push_back(predict_attitude(sample));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_declination(input logic [CSR_W-1:0] value);
      wait_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      decl_setting = value;
   endtask

   function automatic logic [15:0] random_axis();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'h8000;
         2:       return 16'h7FFF;
         3:       return 16'($urandom_range(20)) - 16'd10;
         default: return 16'($urandom);
      endcase
   endfunction

   // Field extremes, zero ordinates, zero mag_y both ways, all-zero sample
   task automatic test_directed();
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF);
      send_sample(16'h8000, 16'h0000, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h0000);
      send_sample(16'h0001, 16'h0001, 16'h0000, 16'hFFFF, 16'h0000, 16'h5555);
      send_sample(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'hAAAA);
      send_sample(16'h4000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000);
      send_sample(16'hC000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000);
      send_sample(16'h0064, 16'hFF9C, 16'hFF9C, 16'hFF9C, 16'h0064, 16'h0000);
      send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h0000);
      send_sample(16'h1234, 16'hFEDC, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      wait_drained();
   endtask

   task automatic test_random(input int count, input int idle_pct, input int stall);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (int n = 0; n < count; n++) begin
         send_sample(random_axis(), random_axis(), random_axis(),
                     random_axis(), random_axis(), 16'($urandom));
      end
      wait_drained();
   endtask

   task automatic test_declination_sweep();
      write_declination(16'sd18000);
      test_random(150, 0, 0);
      write_declination(-16'sd18000);
      test_random(250, 57, 0);
      write_declination(16'h7FFF);
      test_random(250, 0, 57);
      write_declination(16'h8000);
      test_random(200, 9, 9);
      write_declination(16'($urandom_range(36000)) - 16'd18000);
      test_random(250, 0, 0);
   endtask

   // Receiver: randomise ready and check each accepted result
   always @(posedge clock) begin
      attitude_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_angles.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result %h", rsp_tdata);
         end else begin
            want = pending_angles.pop_front();
            if (rsp_tdata[14:0] !== want.pitch || rsp_tdata[30:15] !== want.roll ||
                rsp_tdata[46:31] !== want.heading) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch pitch %0d/%0d roll %0d/%0d heading %0d/%0d",
                           $signed(want.pitch), $signed(rsp_tdata[14:0]),
                           $signed(want.roll), $signed(rsp_tdata[30:15]),
                           $signed(want.heading), $signed(rsp_tdata[46:31]));
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Guard against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_wen       = 1'b0;
      csr_wdata     = '0;
      decl_setting  = 16'd349;
      send_idle_pct = 0;
      stall_pct     = 0;
      error_count   = 0;
      cycle_count   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_declination_sweep();
      if (pending_angles.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: attitude_from_accel_mag_core.f
+incdir+rtl/core
rtl/core/afam_pkg.sv
rtl/core/afam_sqrt.sv
rtl/core/afam_cordic.sv
rtl/core/attitude_from_accel_mag_core.sv
test/tb_attitude_from_accel_mag_core.sv
